[hdl/vdm_pkg.sv]
// Package for the vector distance metric unit: widths, metric codes and the job record.
// The record passes from the accumulating front end through the queue to the back end.
// It depends on nothing else.
`default_nettype none

package vdm_pkg;

   localparam int ACC_W   = 48;
   localparam int MODE_W  = 3;
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = 16;
   localparam int SQ_W    = 2 * MAG_W;

   localparam logic [MODE_W-1:0] MODE_L2        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LINF      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_L2SQUARED = 3'd2;
   localparam logic [MODE_W-1:0] MODE_L1        = 3'd3;

   localparam logic [ACC_W-1:0] ACC_MAX       = 48'hFFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] ROOT_BIT_INIT = 48'h4000_0000_0000;

   typedef struct packed {
      logic             need_root;
      logic [ACC_W-1:0] value;
      logic             sat;
   } job_type;

endpackage

`default_nettype wire

[hdl/vdm_front.sv]
// Front end: takes coordinate pairs, forms |b - a| and its square, and accumulates per vector.
// On the last pair it pushes one finished job into the queue. Uses vdm_pkg.
`default_nettype none

module vdm_front #(
   parameter int DEPTH = 4,
   parameter int CNT_W = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [vdm_pkg::COORD_W-1:0] req_a_value,
   input  wire logic [vdm_pkg::COORD_W-1:0] req_b_value,
   input  wire logic                        req_last,
   input  wire logic [vdm_pkg::MODE_W-1:0]  mode,
   input  wire logic [CNT_W-1:0]            queue_count,
   output logic                             push_valid,
   output vdm_pkg::job_type                 push_job
);
   import vdm_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff;
   logic [MODE_W-1:0]   s1_mode_ff;
   logic [MAG_W-1:0]    s1_mag_ff;
   logic [SQ_W-1:0]     s1_sq_ff;
   logic [ACC_W-1:0]    total_ff, total_in;
   logic                clip_ff, clip_in;

   logic                accept;
   logic [DIFF_W-1:0]   diff;
   logic [MAG_W-1:0]    mag;
   logic [SQ_W-1:0]     sq;
   logic [CNT_W:0]      level;
   logic [ACC_W:0]      sum;
   logic [ACC_W-1:0]    addend;
   logic [ACC_W-1:0]    new_total;
   logic                new_clip;
   logic                known;

   assign level = {1'b0, queue_count} + {{CNT_W{1'b0}}, s1_valid_ff & s1_last_ff};
   assign req_stall = level >= (CNT_W + 1)'(DEPTH);
   assign accept = req_valid && !req_stall;

   always_comb begin
      diff = {req_b_value[COORD_W-1], req_b_value} - {req_a_value[COORD_W-1], req_a_value};
      if (diff[DIFF_W-1]) begin
         mag = MAG_W'(-diff);
      end else begin
         mag = diff[MAG_W-1:0];
      end
      sq = SQ_W'(mag) * SQ_W'(mag);
   end

   always_comb begin
      if (s1_mode_ff == MODE_L1) begin
         addend = ACC_W'(s1_mag_ff);
      end else begin
         addend = ACC_W'(s1_sq_ff);
      end
      sum = {1'b0, total_ff} + {1'b0, addend};
      new_total = total_ff;
      new_clip = clip_ff;
      known = 1'b1;
      case (s1_mode_ff)
         MODE_L2, MODE_L2SQUARED, MODE_L1: begin
            if (sum[ACC_W]) begin
               new_total = ACC_MAX;
               new_clip = 1'b1;
            end else begin
               new_total = sum[ACC_W-1:0];
            end
         end
         MODE_LINF: begin
            if (ACC_W'(s1_mag_ff) > total_ff) begin
               new_total = ACC_W'(s1_mag_ff);
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = accept;
      total_in = total_ff;
      clip_in = clip_ff;
      push_valid = 1'b0;
      push_job.need_root = (s1_mode_ff == MODE_L2);
      push_job.value = known ? new_total : '0;
      push_job.sat = known & new_clip;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            push_valid = 1'b1;
            total_in = '0;
            clip_in = 1'b0;
         end else begin
            total_in = new_total;
            clip_in = new_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         total_ff <= '0;
         clip_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         total_ff <= total_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req_last;
         s1_mode_ff <= mode;
         s1_mag_ff <= mag;
         s1_sq_ff <= sq;
      end
   end

endmodule

`default_nettype wire

[hdl/vdm_queue.sv]
// Short queue of finished jobs between the front end and the back end.
// Uses the job record from vdm_pkg.
`default_nettype none

module vdm_queue #(
   parameter int DEPTH = 4,
   parameter int CNT_W = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire vdm_pkg::job_type push_job,
   input  wire logic             pop,
   output vdm_pkg::job_type      head_job,
   output logic                  not_empty,
   output logic [CNT_W-1:0]      count
);
   import vdm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign not_empty = (count_ff != '0);
   assign count = count_ff;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[hdl/vdm_back.sv]
// Back end: takes jobs from the queue, runs the floor square root for L2 one bit pair a cycle,
// and holds the result in the output register. Uses vdm_pkg.
`default_nettype none

module vdm_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire vdm_pkg::job_type          head_job,
   input  wire logic                      not_empty,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [vdm_pkg::ACC_W-1:0]      rsp_distance,
   output logic                           rsp_saturated
);
   import vdm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_ROOT = 1'b1;

   logic              state_ff, state_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  root_ff, root_in;
   logic [ACC_W-1:0]  bit_ff, bit_in;
   logic              sat_ff, sat_in;
   logic              out_valid_ff, out_valid_in;
   logic [ACC_W-1:0]  out_dist_ff, out_dist_in;
   logic              out_sat_ff, out_sat_in;

   logic              out_free;
   logic [ACC_W-1:0]  trial;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign trial = root_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      sat_in = sat_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_dist_in = out_dist_ff;
      out_sat_in = out_sat_ff;
      pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               if (head_job.need_root) begin
                  pop = 1'b1;
                  rem_in = head_job.value;
                  root_in = '0;
                  bit_in = ROOT_BIT_INIT;
                  sat_in = head_job.sat;
                  state_in = ST_ROOT;
               end else if (out_free) begin
                  pop = 1'b1;
                  out_valid_in = 1'b1;
                  out_dist_in = head_job.value;
                  out_sat_in = head_job.sat;
               end
            end
         end
         ST_ROOT: begin
            if (bit_ff != '0) begin
               if (rem_ff >= trial) begin
                  rem_in = rem_ff - trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_dist_in = root_ff;
               out_sat_in = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      sat_ff <= sat_in;
      out_dist_ff <= out_dist_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

`default_nettype wire

[hdl/vector_distance_metric_unit.sv]
// Top level of the vector distance metric unit: metric register, front end, job queue, back end.
// Instantiates vdm_front, vdm_queue and vdm_back and uses vdm_pkg.
//
// Coordinate pairs are taken one per cycle while the input is not stalled, and each vector
// yields one result on its last pair. The front end accumulates at full rate. The result
// of an L1, L-infinity or squared L2 vector passes from the front-end stage register
// through the job queue to the output register. An L2 result needs the shared square root
// unit, which resolves one root bit per cycle and holds the vector until its root reaches
// the output register. Up to QUEUE_DEPTH finished vectors wait in the queue
// ahead of it, and the input stalls when the queue, counting a finished vector about to enter
// it, is full. The metric register takes a write in every cycle and should be changed only
// while no vector is in flight.
`default_nettype none

module vector_distance_metric_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [vdm_pkg::COORD_W-1:0] req_a_value,
   input  wire logic [vdm_pkg::COORD_W-1:0] req_b_value,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [vdm_pkg::ACC_W-1:0]        rsp_distance,
   output logic                             rsp_saturated,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [vdm_pkg::MODE_W-1:0]  csr_metric_mode
);
   import vdm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               push_valid;
   job_type            push_job;
   job_type            head_job;
   logic               not_empty;
   logic               pop;
   logic [CNT_W-1:0]   queue_count;

   assign csr_ready = 1'b1;
   assign mode_in = (csr_valid && csr_ready) ? csr_metric_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_L2;
      end else begin
         mode_ff <= mode_in;
      end
   end

   vdm_front #(
      .DEPTH (QUEUE_DEPTH),
      .CNT_W (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .req_last    (req_last),
      .mode        (mode_ff),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   vdm_queue #(
      .DEPTH (QUEUE_DEPTH),
      .CNT_W (CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .not_empty  (not_empty),
      .count      (queue_count)
   );

   vdm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .not_empty     (not_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

[hdl/vdm_checker.sv]
// Port-level checker for vector_distance_metric_unit, bound to the top level below.
// It watches the handshakes and counts vectors whose result is still owed. Uses vdm_pkg.
`default_nettype none

module vdm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        req_last,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [vdm_pkg::ACC_W-1:0]   rsp_distance,
   input wire logic                        rsp_saturated
);
   import vdm_pkg::*;

   logic [7:0] pending_ff, pending_in;
   logic       last_in;
   logic       rsp_out;

   assign last_in = req_valid && !req_stall && req_last;
   assign rsp_out = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 8'(last_in) - 8'(rsp_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result transfer needs a vector whose last pair has already been taken.
   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_out |-> pending_ff != '0)
      else $error("result delivered with no vector outstanding");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("outputs not quiet after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance) && $stable(rsp_saturated))
      else $error("stalled result changed");

endmodule

bind vector_distance_metric_unit vdm_checker u_vdm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_distance  (rsp_distance),
   .rsp_saturated (rsp_saturated)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for vector_distance_metric_unit: directed table, then random vectors.
// Depends on vdm_pkg and the unit under test; each result is checked against a typed row
// value or a built-in predictor of L2, L-infinity, squared L2 and L1 with 48-bit saturation.
`timescale 1ns / 1ps

module tb;
   import vdm_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NONE_LO = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NONE_HI = 3'd7;
   localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;
   localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
   localparam logic [ACC_W-1:0] MAX_SQUARE = 48'd4294836225;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 400;
   localparam int PHASES = 12;
   localparam int ITEMS_PER_PHASE = 118;
   localparam int PRESSURE_PHASE = 4;

   typedef struct packed {
      logic [ACC_W-1:0] distance;
      logic             saturated;
   } distance_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic               last;
      logic [16:0]        reps;
      logic               typed;
      logic [ACC_W-1:0]   distance;
      logic               saturated;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_a_value = '0;
   logic [COORD_W-1:0] req_b_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ACC_W-1:0] rsp_distance;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MODE_W-1:0] csr_metric_mode = '0;

   // Typed expectation travelling with the item currently offered.
   logic row_typed = 1'b0;
   logic [ACC_W-1:0] row_distance = '0;
   logic row_saturated = 1'b0;

   distance_type pending_distances[$];
   stim_row_type stim_table[$];
   int mismatch_count = 0;
   bit hold_wanted = 0;
   bit gaps_on = 0;
   int unsigned burst_left = 0;
   logic [MODE_W-1:0] mode_now = MODE_L2;

   // Predictor state.
   logic [MODE_W-1:0] mode_shadow = MODE_L2;
   logic [ACC_W-1:0] metric_total = '0;
   logic metric_clipped = 1'b0;

   vector_distance_metric_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_a_value(req_a_value),
      .req_b_value(req_b_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_metric_mode(csr_metric_mode)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("FAIL vector_distance_metric_unit");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 40)
         $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic [ACC_W-1:0] floor_root(input logic [ACC_W-1:0] v);
      logic [23:0] root;
      logic [23:0] trial;
      logic [ACC_W-1:0] trial_sq;
      root = '0;
      for (int k = 23; k >= 0; k--) begin
         trial = root | (24'd1 << k);
         trial_sq = {24'b0, trial} * {24'b0, trial};
         if (trial_sq <= v)
            root = trial;
      end
      return {24'b0, root};
   endfunction

   // Folds one coordinate pair into the running metric; returns 1 when a result is due.
   function automatic bit fold_pair(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                                    input logic last_in, output distance_type res);
      logic signed [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0] neg;
      logic [ACC_W:0] mag_w;
      logic [ACC_W:0] sum;
      diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
      neg = -diff;
      mag_w = diff[DIFF_W-1] ? {32'b0, neg} : {32'b0, diff};
      sum = {1'b0, metric_total};
      case (mode_shadow)
         MODE_L2, MODE_L2SQUARED: sum = sum + mag_w * mag_w;
         MODE_L1: sum = sum + mag_w;
         MODE_LINF: if (mag_w > sum) sum = mag_w;
         default: ;
      endcase
      if (sum > {1'b0, ACC_MAX}) begin
         sum = {1'b0, ACC_MAX};
         metric_clipped = 1'b1;
      end
      metric_total = sum[ACC_W-1:0];
      res = '0;
      if (!last_in)
         return 0;
      case (mode_shadow)
         MODE_L2: res = '{floor_root(metric_total), metric_clipped};
         MODE_LINF, MODE_L2SQUARED, MODE_L1: res = '{metric_total, metric_clipped};
         default: res = '0;
      endcase
      metric_total = '0;
      metric_clipped = 1'b0;
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      distance_type predicted;
      distance_type queued;
      distance_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            mode_shadow = csr_metric_mode;
         if (req_valid && !req_stall) begin
            if (fold_pair(req_a_value, req_b_value, req_last, predicted)) begin
               queued = row_typed ? distance_type'({row_distance, row_saturated}) : predicted;
               pending_distances = {pending_distances, queued};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_distances.size() == 0) begin
               report_mismatch("result with none expected", 64'(rsp_distance), 64'd0);
            end else begin
               want = pending_distances.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", 64'(rsp_distance), 64'(want.distance));
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 64'(rsp_saturated), 64'(want.saturated));
            end
         end
      end
   end

   initial begin : rsp_side
      int unsigned seg_len;
      int unsigned stall_pct;
      @(negedge reset);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         seg_len = $urandom_range(1, 60);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         repeat (seg_len) begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   task automatic send_pair(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                            input logic l, input logic t, input logic [ACC_W-1:0] d,
                            input logic s);
      int unsigned gap;
      req_valid <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      req_last <= l;
      row_typed <= t;
      row_distance <= d;
      row_saturated <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            req_a_value <= COORD_W'($urandom_range(0, 65535));
            req_b_value <= COORD_W'($urandom_range(0, 65535));
            req_last <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Waits until every result has arrived and the back end has gone quiet, then writes the mode.
   task automatic set_metric_mode(input logic [MODE_W-1:0] m);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_metric_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_now = m;
   endtask

   task automatic add_row(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] a,
                          input logic [COORD_W-1:0] b, input logic l, input int r,
                          input logic t, input logic [ACC_W-1:0] d, input logic s);
      stim_row_type row;
      row.mode = m;
      row.a = a;
      row.b = b;
      row.last = l;
      row.reps = 17'(r);
      row.typed = t;
      row.distance = d;
      row.saturated = s;
      stim_table = {stim_table, row};
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] small_val;
      case ($urandom_range(0, 19))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3, 4, 5: begin
            small_val = COORD_W'($urandom_range(0, 512));
            return $urandom_range(0, 1) ? -small_val : small_val;
         end
         default: return COORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin : req_side
      logic [MODE_W-1:0] phase_modes[PHASES];
      int sent;
      int len;
      phase_modes = '{MODE_L2, MODE_L1, MODE_LINF, MODE_L2SQUARED, MODE_L2, MODE_NONE_HI,
                      MODE_L1, MODE_L2SQUARED, MODE_LINF, MODE_NONE_LO, MODE_L2, MODE_L1};

      // mode, a, b, last, repeats, typed, distance, saturated
      add_row(MODE_L2, 16'h0000, 16'h0000, 1, 1, 1, 48'd0, 0);
      add_row(MODE_L2, COORD_MIN, COORD_MAX, 1, 1, 1, 48'd65535, 0);
      add_row(MODE_L2, 16'h0100, 16'h0200, 0, 1, 0, '0, 0);
      add_row(MODE_L2, 16'h0000, 16'hFD00, 0, 1, 0, '0, 0);
      add_row(MODE_L2, 16'hFFFF, 16'h0001, 1, 1, 0, '0, 0);
      add_row(MODE_L2SQUARED, COORD_MIN, COORD_MAX, 1, 1, 1, MAX_SQUARE, 0);
      add_row(MODE_L2SQUARED, COORD_MAX, COORD_MAX, 1, 1, 1, 48'd0, 0);
      add_row(MODE_L1, COORD_MAX, COORD_MIN, 1, 1, 1, 48'd65535, 0);
      add_row(MODE_L1, 16'hFFFF, 16'hFFFF, 0, 1, 0, '0, 0);
      add_row(MODE_L1, 16'h0064, 16'hFF9C, 1, 1, 0, '0, 0);
      add_row(MODE_LINF, COORD_MAX, COORD_MIN, 1, 1, 1, 48'd65535, 0);
      add_row(MODE_LINF, 16'h0005, 16'h0005, 1, 1, 1, 48'd0, 0);
      add_row(MODE_LINF, 16'h0000, 16'hFFFD, 0, 1, 0, '0, 0);
      add_row(MODE_LINF, 16'h0000, 16'h0064, 0, 1, 0, '0, 0);
      add_row(MODE_LINF, 16'h0007, 16'h0007, 1, 1, 0, '0, 0);
      add_row(MODE_NONE_LO, COORD_MIN, COORD_MAX, 0, 1, 0, '0, 0);
      add_row(MODE_NONE_LO, 16'h0001, 16'hFFFF, 1, 1, 1, 48'd0, 0);
      add_row(MODE_NONE_HI, 16'h1234, 16'h8765, 1, 1, 1, 48'd0, 0);
      // The mode changes partway through a vector, including to an unknown mode.
      add_row(MODE_L1, 16'h0064, 16'hFF9C, 0, 1, 0, '0, 0);
      add_row(MODE_L2SQUARED, 16'h0000, 16'h012C, 1, 1, 0, '0, 0);
      add_row(MODE_L2SQUARED, 16'h000A, 16'h0014, 0, 1, 0, '0, 0);
      add_row(MODE_NONE_LO, 16'h0001, 16'h0002, 1, 1, 1, 48'd0, 0);
      add_row(MODE_L2SQUARED, 16'h0000, 16'h0010, 1, 1, 0, '0, 0);
      // A vector longer than the nominal length is still taken.
      add_row(MODE_L1, COORD_MAX, COORD_MIN, 1, 300, 0, '0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].mode != mode_now)
            set_metric_mode(stim_table[i].mode);
         gaps_on = (stim_table[i].reps < 1000);
         for (int r = 1; r <= stim_table[i].reps; r++)
            send_pair(stim_table[i].a, stim_table[i].b,
                      stim_table[i].last && (r == stim_table[i].reps),
                      stim_table[i].typed && (r == stim_table[i].reps),
                      stim_table[i].distance, stim_table[i].saturated);
      end

      for (int p = 0; p < PHASES; p++) begin
         set_metric_mode(phase_modes[p]);
         gaps_on = (p % 3 != 2) && (p != PRESSURE_PHASE);
         if (p == PRESSURE_PHASE)
            hold_wanted = 1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (p == PRESSURE_PHASE)
               len = $urandom_range(1, 2);
            else if ($urandom_range(0, 9) == 0)
               len = $urandom_range(7, 40);
            else
               len = $urandom_range(1, 6);
            for (int k = 1; k <= len; k++)
               send_pair(pick_coord(), pick_coord(), k == len, 1'b0, '0, 1'b0);
            sent += len;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS vector_distance_metric_unit");
      else
         $display("FAIL vector_distance_metric_unit");
      $finish;
   end

endmodule
